@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the RTL of the line index locator.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define LIL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define LIL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

@@ hw/rtl/lil_pkg.sv @@
// Package for the line index locator: capacities, widths, opcodes and states.
// No dependencies; imported by line_index_locator_core.
`default_nettype none

package lil_pkg;

    localparam int MAX_BYTES = 65536;
    localparam int MAX_LINES = 4096;

    localparam int LEN_W  = $clog2(MAX_BYTES + 1);
    localparam int LINE_W = $clog2(MAX_LINES + 1);
    localparam int ADDR_W = $clog2(MAX_LINES);

    localparam int OPCODE_W = 2;
    localparam int BYTE_W   = 8;
    localparam int QUERY_W  = 17;
    localparam int LNUM_W   = 13;
    localparam int COL_W    = 17;
    localparam int OFS_W    = 17;

    // Common widths for comparing a query against the counters
    localparam int POSCMP_W = (LEN_W > QUERY_W) ? LEN_W : QUERY_W;
    localparam int LNCMP_W  = (LINE_W > QUERY_W) ? LINE_W : QUERY_W;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 64;
    localparam int S_TUSER_W = OPCODE_W;
    localparam int M_TUSER_W = 2;

    localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_LOCATE = 2'd2,
        OP_BOUNDS = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOC_EVAL,
        ST_BND_FIRST,
        ST_BND_SECOND,
        ST_BND_TRIM,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/lil_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lil_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/line_index_locator_core.sv @@
// Line index locator: builds a line-start table from a byte stream and
// answers offset-to-line/column and line-bounds queries.
// Depends on lil_pkg, lil_ram and assert_macros.svh.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser holds the
//   opcode. Clear and append produce no beat and leave the block idle, so text
//   loads at one byte per clock. Locate and bounds each produce one beat on
//   m_tvalid/m_tready/m_tdata/m_tuser. One item is worked on at a time;
//   s_tready is high only while idle.
//   Locate: a binary search over the line-start table with one start-RAM read
//   per search step, then the output load.
//   Bounds: one start-RAM read for the last line, two for others, then a trim
//   step and the output load; a bad line number goes straight to the load.
//   Stall: a finished beat waits in the output register and a new item is
//   still accepted; its result holds in the load step until m_tready drains it.
//   Reset (aresetn low, synchronous): line count one, length zero, overflow
//   clear. No RAM clearing pass: entry 0 always reads as zero and no other
//   entry is read before the current buffer has written it.
`default_nettype none

module line_index_locator_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // s_tdata: data_byte [7:0], query_value [24:8], zero pad [31:25]
    input  wire logic [lil_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: opcode [1:0]
    input  wire logic [lil_pkg::S_TUSER_W-1:0]   s_tuser,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // m_tdata: line_no [12:0], column [29:13], line_start [46:30],
    //          line_end [63:47]
    output logic      [lil_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: no_such_line [0], overflowed [1]
    output logic      [lil_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready
);

    import lil_pkg::*;

    // ------------------------------------------------------------------
    // Input beat fields
    // ------------------------------------------------------------------
    op_t                in_op;
    logic [BYTE_W-1:0]  in_byte;
    logic [QUERY_W-1:0] in_query;
    logic               in_fire;

    assign in_op    = op_t'(s_tuser[OPCODE_W-1:0]);
    assign in_byte  = s_tdata[BYTE_W-1:0];
    assign in_query = s_tdata[BYTE_W+QUERY_W-1:BYTE_W];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LINE_W-1:0]   lcount_reg, lcount_next;
    logic                last_cr_reg, last_cr_next;
    logic                ovf_reg, ovf_next;
    logic                m_valid_reg, m_valid_next;

    // search and query working registers (payload, no reset)
    logic [LINE_W-1:0]   lo_reg, lo_next;
    logic [LINE_W-1:0]   hi_reg, hi_next;
    logic [LINE_W-1:0]   mid_reg, mid_next;
    logic [LEN_W-1:0]    pos_reg, pos_next;
    logic [LEN_W-1:0]    best_reg, best_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [LEN_W-1:0]    s_reg, s_next;
    logic [LEN_W-1:0]    e_reg, e_next;
    logic                cr_reg, cr_next;

    // result staging and output register
    logic [LNUM_W-1:0]   res_line_reg, res_line_next;
    logic [COL_W-1:0]    res_col_reg, res_col_next;
    logic [OFS_W-1:0]    res_start_reg, res_start_next;
    logic [OFS_W-1:0]    res_end_reg, res_end_next;
    logic                res_bad_reg, res_bad_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [M_TUSER_W-1:0] m_user_reg, m_user_next;

    // ------------------------------------------------------------------
    // Line-start table and per-line carriage-return flags
    // ------------------------------------------------------------------
    logic               start_we;
    logic [ADDR_W-1:0]  start_waddr;
    logic [LEN_W-1:0]   start_wdata;
    logic [ADDR_W-1:0]  rd_addr;
    logic [LEN_W-1:0]   start_rdata;
    logic               cr_we;
    logic [ADDR_W-1:0]  cr_waddr;
    logic               cr_wdata;
    logic               cr_rdata;

    lil_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_LINES)
    ) u_start_ram (
        .aclk    (aclk),
        .wr_en   (start_we),
        .wr_addr (start_waddr),
        .wr_data (start_wdata),
        .rd_addr (rd_addr),
        .rd_data (start_rdata)
    );

    lil_ram #(
        .WIDTH (1),
        .DEPTH (MAX_LINES)
    ) u_cr_ram (
        .aclk    (aclk),
        .wr_en   (cr_we),
        .wr_addr (cr_waddr),
        .wr_data (cr_wdata),
        .rd_addr (rd_addr),
        .rd_data (cr_rdata)
    );

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // ------------------------------------------------------------------
    // Shared helpers for the datapath
    // ------------------------------------------------------------------
    logic                out_free;
    logic                query_bad;
    logic [LEN_W-1:0]    clamp_pos;
    logic [LEN_W-1:0]    tbl_val;
    logic                tbl_le;
    logic [LINE_W-1:0]   lo_upd, hi_upd, mid_upd;
    logic [LEN_W-1:0]    best_upd;
    logic                search_more;
    logic                has_next_line;
    logic [LINE_W-1:0]   idx_plus1;

    assign out_free = !m_valid_reg || m_tready;

    // line number 0 or past the line count has no bounds
    assign query_bad = (in_query == '0) ||
                       (LNCMP_W'(in_query) > LNCMP_W'(lcount_reg));

    // clamp the locate offset to the content length
    assign clamp_pos = (POSCMP_W'(in_query) > POSCMP_W'(len_reg)) ?
                       len_reg : LEN_W'(in_query);

    // entry 0 of the table is always zero
    assign tbl_val = (mid_reg == '0) ? '0 : start_rdata;
    assign tbl_le  = (tbl_val <= pos_reg);
    assign lo_upd  = tbl_le ? (mid_reg + LINE_W'(1)) : lo_reg;
    assign hi_upd  = tbl_le ? hi_reg : mid_reg;
    assign best_upd = tbl_le ? tbl_val : best_reg;
    assign mid_upd = lo_upd + ((hi_upd - lo_upd) >> 1);
    assign search_more = (lo_upd < hi_upd);

    assign idx_plus1     = LINE_W'(idx_reg) + LINE_W'(1);
    assign has_next_line = (idx_plus1 < lcount_reg);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (in_op)
                        OP_LOCATE: state_next = ST_LOC_EVAL;
                        OP_BOUNDS: state_next = query_bad ? ST_OUT : ST_BND_FIRST;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOC_EVAL: begin
                if (!search_more) begin
                    state_next = ST_OUT;
                end
            end
            ST_BND_FIRST: begin
                state_next = has_next_line ? ST_BND_SECOND : ST_BND_TRIM;
            end
            ST_BND_SECOND: state_next = ST_BND_TRIM;
            ST_BND_TRIM:   state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and RAM control
    // ------------------------------------------------------------------
    always_comb begin
        len_next       = len_reg;
        lcount_next    = lcount_reg;
        last_cr_next   = last_cr_reg;
        ovf_next       = ovf_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        pos_next       = pos_reg;
        best_next      = best_reg;
        idx_next       = idx_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        cr_next        = cr_reg;
        res_line_next  = res_line_reg;
        res_col_next   = res_col_reg;
        res_start_next = res_start_reg;
        res_end_next   = res_end_reg;
        res_bad_next   = res_bad_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        m_valid_next   = m_valid_reg && !m_tready;

        start_we    = 1'b0;
        start_waddr = lcount_reg[ADDR_W-1:0];
        start_wdata = len_reg + LEN_W'(1);
        cr_we       = 1'b0;
        cr_waddr    = ADDR_W'(lcount_reg - LINE_W'(1));
        cr_wdata    = last_cr_reg;
        rd_addr     = mid_upd[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (in_op == OP_LOCATE) begin
                    rd_addr = ADDR_W'(lcount_reg >> 1);
                end else begin
                    rd_addr = ADDR_W'(in_query - QUERY_W'(1));
                end
                if (in_fire) begin
                    case (in_op)
                        OP_CLEAR: begin
                            len_next     = '0;
                            lcount_next  = LINE_W'(1);
                            last_cr_next = 1'b0;
                            ovf_next     = 1'b0;
                        end
                        OP_APPEND: begin
                            if (len_reg == LEN_W'(MAX_BYTES)) begin
                                ovf_next = 1'b1;
                            end else if (in_byte == BYTE_LF) begin
                                if (lcount_reg == LINE_W'(MAX_LINES)) begin
                                    // drop the newline entirely
                                    ovf_next = 1'b1;
                                end else begin
                                    start_we     = 1'b1;
                                    cr_we        = 1'b1;
                                    lcount_next  = lcount_reg + LINE_W'(1);
                                    len_next     = len_reg + LEN_W'(1);
                                    last_cr_next = 1'b0;
                                end
                            end else begin
                                len_next     = len_reg + LEN_W'(1);
                                last_cr_next = (in_byte == BYTE_CR);
                            end
                        end
                        OP_LOCATE: begin
                            lo_next   = '0;
                            hi_next   = lcount_reg;
                            mid_next  = lcount_reg >> 1;
                            pos_next  = clamp_pos;
                            best_next = '0;
                        end
                        OP_BOUNDS: begin
                            idx_next = ADDR_W'(in_query - QUERY_W'(1));
                            if (query_bad) begin
                                res_line_next  = '0;
                                res_col_next   = '0;
                                res_start_next = '0;
                                res_end_next   = '0;
                                res_bad_next   = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOC_EVAL: begin
                // read data for mid_reg is valid; narrow and issue next read
                lo_next   = lo_upd;
                hi_next   = hi_upd;
                mid_next  = mid_upd;
                best_next = best_upd;
                rd_addr   = mid_upd[ADDR_W-1:0];
                if (!search_more) begin
                    // located index is lo - 1, so the 1-based line is lo
                    res_line_next  = LNUM_W'(lo_upd);
                    res_col_next   = COL_W'(pos_reg - best_upd + LEN_W'(1));
                    res_start_next = OFS_W'(best_upd);
                    res_end_next   = '0;
                    res_bad_next   = 1'b0;
                end
            end
            ST_BND_FIRST: begin
                rd_addr = idx_plus1[ADDR_W-1:0];
                s_next  = (idx_reg == '0) ? '0 : start_rdata;
                if (has_next_line) begin
                    cr_next = cr_rdata;
                end else begin
                    // last line ends at the content end
                    e_next  = len_reg;
                    cr_next = last_cr_reg;
                end
            end
            ST_BND_SECOND: begin
                // next line starts after the newline
                e_next = start_rdata - LEN_W'(1);
            end
            ST_BND_TRIM: begin
                res_line_next  = '0;
                res_col_next   = '0;
                res_start_next = OFS_W'(s_reg);
                res_end_next   = (cr_reg && (e_reg > s_reg)) ?
                                 OFS_W'(e_reg - LEN_W'(1)) : OFS_W'(e_reg);
                res_bad_next   = 1'b0;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_end_reg, res_start_reg, res_col_reg, res_line_reg};
                    m_user_next  = {ovf_reg, res_bad_reg};
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            lcount_reg  <= LINE_W'(1);
            last_cr_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            lcount_reg  <= lcount_next;
            last_cr_reg <= last_cr_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        pos_reg       <= pos_next;
        best_reg      <= best_next;
        idx_reg       <= idx_next;
        s_reg         <= s_next;
        e_reg         <= e_next;
        cr_reg        <= cr_next;
        res_line_reg  <= res_line_next;
        res_col_reg   <= res_col_next;
        res_start_reg <= res_start_next;
        res_end_reg   <= res_end_next;
        res_bad_reg   <= res_bad_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `include "assert_macros.svh"

    // the search window never collapses while a read is outstanding
    `LIL_ASSERT(a_search_window, (state_reg == ST_LOC_EVAL) |-> (lo_reg < hi_reg), "search window empty")
    // a result beat appears only after the output-load step
    `LIL_ASSERT(a_out_from_load, $rose(m_valid_reg) |-> $past(state_reg == ST_OUT), "beat without load")
    // line count changes only through an accepted beat
    `LIL_ASSERT(a_lcount_by_beat, (lcount_reg != $past(lcount_reg)) |-> $past(in_fire), "line count moved")
    // counters stay within capacity
    `LIL_ASSERT_ALWAYS(a_capacity, !aresetn || ((lcount_reg != '0) && (lcount_reg <= LINE_W'(MAX_LINES)) && (len_reg <= LEN_W'(MAX_BYTES))), "capacity exceeded")

endmodule

`default_nettype wire
